// ===== src/mono_glyph_blitter_macros.svh =====
// assertion macros shared by the blitter checker
// no dependencies
`ifndef MONO_GLYPH_BLITTER_MACROS_SVH
`define MONO_GLYPH_BLITTER_MACROS_SVH

// same-cycle implication
`define MGB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mgb check failed");

// next-cycle implication
`define MGB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mgb check failed");

// next-cycle implication checked through reset
`define MGB_ASSERT_NEXT_NR(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("mgb check failed");

`endif

// ===== src/mgb_pkg.sv =====
// types and constants of the glyph blitter
// no dependencies
package mgb_pkg;

   localparam int GW_W   = 7;
   localparam int GH_W   = 7;
   localparam int SW_W   = 11;
   localparam int SH_W   = 10;
   localparam int CSR_W  = 11;
   localparam int POS_W  = 11;
   localparam int PIX_W  = 13;
   localparam int SADR_W = 21;

   localparam logic [GW_W-1:0] GW_RESET = 7'd19;
   localparam logic [GH_W-1:0] GH_RESET = 7'd25;
   localparam logic [SW_W-1:0] SW_RESET = 11'd800;
   localparam logic [SH_W-1:0] SH_RESET = 10'd480;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_DRAW  = 2'd1,
      OP_READ  = 2'd2,
      OP_WRITE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      REG_GW = 2'd0,
      REG_GH = 2'd1,
      REG_SW = 2'd2,
      REG_SH = 2'd3
   } reg_type;

   typedef struct packed {
      logic capture;
      logic pix_clear;
      logic pix_step;
      logic pix_stage;
      logic pix_fetch;
      logic pix_write;
      logic glyph_load;
      logic scr_read;
      logic scr_write;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic draw_empty;
      logic pix_last;
   } stat_type;

endpackage

// ===== src/mgb_ctrl.sv =====
// sequencer of the glyph blitter
// depends on mgb_pkg
module mgb_ctrl import mgb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic [1:0] req_operation,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_GLOAD, ST_SREAD, ST_SWRITE, ST_PADDR, ST_PREAD, ST_PWRITE, ST_DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;
   logic      slot_free;
   op_type    op_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign op_in     = op_type'(req_operation);

   always_comb begin
      cmd            = '0;
      cmd.capture    = accept;
      cmd.pix_clear  = accept;
      cmd.glyph_load = (state_ff == ST_GLOAD);
      cmd.scr_read   = (state_ff == ST_SREAD);
      cmd.scr_write  = (state_ff == ST_SWRITE);
      cmd.pix_stage  = (state_ff == ST_PADDR);
      cmd.pix_fetch  = (state_ff == ST_PREAD);
      cmd.pix_write  = (state_ff == ST_PWRITE);
      cmd.pix_step   = (state_ff == ST_PWRITE) && !stat.pix_last;
      cmd.rsp_load   = (state_ff == ST_DONE) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  unique case (op_in)
                     OP_LOAD:  state_ff <= ST_GLOAD;
                     OP_DRAW:  state_ff <= stat.draw_empty ? ST_DONE : ST_PADDR;
                     OP_READ:  state_ff <= ST_SREAD;
                     OP_WRITE: state_ff <= ST_SWRITE;
                     default:  state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_GLOAD:  state_ff <= ST_DONE;
            ST_SREAD:  state_ff <= ST_DONE;
            ST_SWRITE: state_ff <= ST_DONE;
            ST_PADDR:  state_ff <= ST_PREAD;
            ST_PREAD:  state_ff <= ST_PWRITE;
            ST_PWRITE: state_ff <= stat.pix_last ? ST_DONE : ST_PADDR;
            ST_DONE: begin
               if (slot_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default:   state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== src/mgb_datapath.sv =====
// registers, pixel walk arithmetic, glyph and screen memories
// depends on mgb_pkg
module mgb_datapath import mgb_pkg::*; #(
   parameter int SCREEN_BYTES   = 65536,
   parameter int GLYPH_BYTES    = 512,
   parameter int MAX_GLYPH_SIDE = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [CSR_W-1:0]  csr_wdata,
   input  logic [1:0]        req_operation,
   input  logic [8:0]        req_glyph_offset,
   input  logic [7:0]        req_data_byte,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic              req_ink_white,
   input  logic              req_glyph_present,
   input  logic [15:0]       req_screen_address,
   output logic [6:0]        rsp_advance,
   output logic [7:0]        rsp_read_data
);

   localparam int SA_W   = $clog2(SCREEN_BYTES);
   localparam int GA_W   = $clog2(GLYPH_BYTES);
   localparam int SIDE_W = $clog2(MAX_GLYPH_SIDE + 1);
   localparam int GSTR_W = $clog2((MAX_GLYPH_SIDE + 7) / 8 + 1);
   localparam int GIDX_W = SIDE_W + GSTR_W;

   logic [GW_W-1:0] gw_ff;
   logic [GH_W-1:0] gh_ff;
   logic [SW_W-1:0] sw_ff;
   logic [SH_W-1:0] sh_ff;

   op_type           op_ff;
   logic [8:0]       goff_ff;
   logic [7:0]       data_ff;
   logic signed [POS_W-1:0] x_ff, y_ff;
   logic             white_ff, present_ff;
   logic [15:0]      addr_ff;

   logic [SIDE_W-1:0] row_ff, col_ff;
   logic [SIDE_W-1:0] w_sat, h_sat;
   logic [GSTR_W-1:0] gstride;

   logic signed [PIX_W-1:0] px, py;
   logic [8:0]        stride;
   logic [SADR_W-1:0] saddr;
   logic [GIDX_W-1:0] gidx;
   logic              in_range, border;

   logic              pix_ok_ff, gidx_ok_ff, border_ff;
   logic [SA_W-1:0]   saddr_ff;
   logic [GA_W-1:0]   gidx_ff;
   logic [2:0]        bitsel_ff, gbit_ff;

   logic [7:0] scr_mem [SCREEN_BYTES];
   logic [7:0] glyph_mem [GLYPH_BYTES];
   logic [7:0] scr_q_ff, glyph_q_ff;
   logic [6:0] advance_ff;
   logic [7:0] read_data_ff;

   logic            addr_ok, goff_ok, pix_on, scr_we, scr_re;
   logic [SA_W-1:0] scr_a;
   logic [7:0]      scr_wd, mask;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gw_ff <= GW_RESET;
         gh_ff <= GH_RESET;
         sw_ff <= SW_RESET;
         sh_ff <= SH_RESET;
      end else if (csr_we) begin
         unique case (reg_type'(csr_index))
            REG_GW:  gw_ff <= csr_wdata[GW_W-1:0];
            REG_GH:  gh_ff <= csr_wdata[GH_W-1:0];
            REG_SW:  sw_ff <= csr_wdata[SW_W-1:0];
            REG_SH:  sh_ff <= csr_wdata[SH_W-1:0];
            default: gw_ff <= gw_ff;
         endcase
      end
   end

   // saturated glyph size
   always_comb begin
      w_sat = (int'(gw_ff) > MAX_GLYPH_SIDE) ? SIDE_W'(MAX_GLYPH_SIDE) : SIDE_W'(gw_ff);
      h_sat = (int'(gh_ff) > MAX_GLYPH_SIDE) ? SIDE_W'(MAX_GLYPH_SIDE) : SIDE_W'(gh_ff);
      gstride = GSTR_W'(({1'b0, w_sat} + (SIDE_W + 1)'(7)) >> 3);
   end

   assign stat.draw_empty = (w_sat == '0) || (h_sat == '0);
   assign stat.pix_last   = (row_ff == h_sat - SIDE_W'(1)) && (col_ff == w_sat - SIDE_W'(1));

   // request capture and pixel counters
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= op_type'(req_operation);
         goff_ff    <= req_glyph_offset;
         data_ff    <= req_data_byte;
         x_ff       <= req_pos_x;
         y_ff       <= req_pos_y;
         white_ff   <= req_ink_white;
         present_ff <= req_glyph_present;
         addr_ff    <= req_screen_address;
      end
      if (cmd.pix_clear) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (cmd.pix_step) begin
         if (col_ff == w_sat - SIDE_W'(1)) begin
            col_ff <= '0;
            row_ff <= row_ff + SIDE_W'(1);
         end else begin
            col_ff <= col_ff + SIDE_W'(1);
         end
      end
   end

   // pixel address stage
   always_comb begin
      px       = PIX_W'(x_ff) + signed'(PIX_W'(col_ff));
      py       = PIX_W'(y_ff) + signed'(PIX_W'(row_ff));
      in_range = !px[PIX_W-1] && !py[PIX_W-1]
                 && (px < signed'(PIX_W'(sw_ff))) && (py < signed'(PIX_W'(sh_ff)));
      stride   = 9'((12'(sw_ff) + 12'd7) >> 3);
      saddr    = SADR_W'(py[9:0] * stride) + SADR_W'(px[10:3]);
      gidx     = GIDX_W'(row_ff * gstride) + GIDX_W'(col_ff >> 3);
      border   = (row_ff == '0) || (row_ff == h_sat - SIDE_W'(1))
                 || (col_ff == '0) || (col_ff == w_sat - SIDE_W'(1));
   end

   always_ff @(posedge clock) begin
      if (cmd.pix_stage) begin
         pix_ok_ff  <= in_range && (32'(saddr) < 32'(SCREEN_BYTES));
         saddr_ff   <= SA_W'(saddr);
         gidx_ok_ff <= 32'(gidx) < 32'(GLYPH_BYTES);
         gidx_ff    <= GA_W'(gidx);
         border_ff  <= border;
         bitsel_ff  <= px[2:0];
         gbit_ff    <= col_ff[2:0];
      end
   end

   // memories
   assign addr_ok = 32'(addr_ff) < 32'(SCREEN_BYTES);
   assign goff_ok = 32'(goff_ff) < 32'(GLYPH_BYTES);
   assign mask    = 8'h80 >> bitsel_ff;
   assign pix_on  = pix_ok_ff
                    && (present_ff ? (gidx_ok_ff && glyph_q_ff[~gbit_ff]) : border_ff);
   assign scr_a   = (op_ff == OP_DRAW) ? saddr_ff : SA_W'(addr_ff);
   assign scr_re  = cmd.scr_read || cmd.pix_fetch;
   assign scr_we  = (cmd.scr_write && addr_ok) || (cmd.pix_write && pix_on);
   assign scr_wd  = cmd.scr_write ? data_ff
                    : (white_ff ? (scr_q_ff | mask) : (scr_q_ff & ~mask));

   always_ff @(posedge clock) begin
      if (scr_we) begin
         scr_mem[scr_a] <= scr_wd;
      end
      if (scr_re) begin
         scr_q_ff <= scr_mem[scr_a];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.glyph_load && goff_ok) begin
         glyph_mem[GA_W'(goff_ff)] <= data_ff;
      end
      if (cmd.pix_fetch) begin
         glyph_q_ff <= glyph_mem[gidx_ff];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         advance_ff   <= (op_ff == OP_DRAW) ? 7'(w_sat) : 7'h00;
         read_data_ff <= ((op_ff == OP_READ) && addr_ok) ? scr_q_ff : 8'h00;
      end
   end

   assign rsp_advance   = advance_ff;
   assign rsp_read_data = read_data_ff;

endmodule

// ===== src/mono_glyph_blitter.sv =====
// one-bit glyph blitter with clipping, top level
// depends on mgb_pkg, mgb_ctrl, mgb_datapath
//
// usage:
// - req channel carries one request: load a glyph byte, draw the glyph at a
//   signed x,y, read a screen byte or write a screen byte
// - rsp channel returns one item per request: advance for a draw, read_data
//   for a read, zero otherwise
// - csr channel writes glyph_width, glyph_height, screen_width, screen_height;
//   always ready, write only while no request is in flight
// - one request in flight; req_ready is high only while the sequencer idles
// - load, read and write pass through their operation state and the done state before rsp_valid
// - a draw visits the address, memory read and write back states (write back
//   through the single framebuffer port) for every glyph pixel, then the done
//   state; a zero sized glyph goes straight to the done state
// - the finished result sits in an output register; if the receiver stalls,
//   the sequencer holds in its done state until the register frees, and the
//   next request can be accepted while that result still waits there
// - reset clears control and config registers; glyph and screen memories are
//   not cleared and must be written before they are read
module mono_glyph_blitter import mgb_pkg::*; #(
   parameter int SCREEN_BYTES   = 65536,
   parameter int GLYPH_BYTES    = 512,
   parameter int MAX_GLYPH_SIDE = 64
) (
   input  logic              clock,
   input  logic              reset,
   // configuration
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [CSR_W-1:0]  csr_wdata,
   // requests
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_operation,
   input  logic [8:0]        req_glyph_offset,
   input  logic [7:0]        req_data_byte,
   input  logic signed [POS_W-1:0] req_pos_x,
   input  logic signed [POS_W-1:0] req_pos_y,
   input  logic              req_ink_white,
   input  logic              req_glyph_present,
   input  logic [15:0]       req_screen_address,
   // results
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [6:0]        rsp_advance,
   output logic [7:0]        rsp_read_data
);

   cmd_type  cmd;
   stat_type stat;

   // config writes never stall
   assign csr_ready = 1'b1;

   mgb_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   mgb_datapath #(
      .SCREEN_BYTES   (SCREEN_BYTES),
      .GLYPH_BYTES    (GLYPH_BYTES),
      .MAX_GLYPH_SIDE (MAX_GLYPH_SIDE)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .csr_we             (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_operation      (req_operation),
      .req_glyph_offset   (req_glyph_offset),
      .req_data_byte      (req_data_byte),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_ink_white      (req_ink_white),
      .req_glyph_present  (req_glyph_present),
      .req_screen_address (req_screen_address),
      .rsp_advance        (rsp_advance),
      .rsp_read_data      (rsp_read_data)
   );

endmodule

// ===== src/mgb_checker.sv =====
// port-level checks of the glyph blitter, bound to the top level
// depends on mono_glyph_blitter_macros.svh
`include "mono_glyph_blitter_macros.svh"

module mgb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_advance,
   input logic [7:0] rsp_read_data
);

   // a waiting result is not withdrawn
   `MGB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // a result carries at most one nonzero field
   `MGB_ASSERT_NOW(a_one_field, clock, reset, rsp_valid && (rsp_read_data != 8'h00),
      rsp_advance == 7'd0)

   // one request at a time
   `MGB_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready)

   // reset empties the result register
   `MGB_ASSERT_NEXT_NR(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind mono_glyph_blitter mgb_checker u_mgb_checker (.*);
